// ----- sv/egcd_pkg.sv -----
// shared constants for the extended gcd / modular inverse core
// no dependencies
package egcd_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;

endpackage

// ----- sv/egcd_if.sv -----
// valid/ready channel interfaces for operand and result beats
// depends on egcd_pkg
interface egcd_in_if #(
  parameter int unsigned DataWidth = egcd_pkg::DATA_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] operand_a;
  logic signed [DataWidth-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_out_if #(
  parameter int unsigned DataWidth = egcd_pkg::DATA_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic        [DataWidth-2:0] gcd_value;
  logic signed [DataWidth-1:0] coeff_x;
  logic signed [DataWidth-1:0] coeff_y;
  logic        [DataWidth-2:0] inverse_value;
  logic                        inverse_valid;

  modport source (
    output valid, output gcd_value, output coeff_x, output coeff_y,
    output inverse_value, output inverse_valid, input ready
  );
  modport sink (
    input valid, input gcd_value, input coeff_x, input coeff_y,
    input inverse_value, input inverse_valid, output ready
  );
endinterface

// ----- sv/extended_gcd_mod_inverse_core.sv -----
// extended euclid core: gcd, bezout coefficients and inverse of a mod b
// the shared divider (one quotient bit per cycle) runs once per euclid step and once more
// when the inverse is formed; an operand beat is taken only in idle, after the previous
// result has moved into the output register, where a result beat waits until it is taken
// reset: asynchronous active low, clears the sequencer and the output valid
module extended_gcd_mod_inverse_core #(
  parameter int unsigned DataWidth = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  egcd_in_if.sink    in_i,
  egcd_out_if.source out_o
);
  import egcd_pkg::*;

  localparam int unsigned MagW = DataWidth - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_INV,
    ST_DONE
  } state_e;

  function automatic logic [MagW-1:0] mag_sat(input logic [DataWidth-1:0] v);
    logic [DataWidth-1:0] n;
    logic [MagW-1:0]      m;
    n = -v;
    if (!v[DataWidth-1]) begin
      m = v[MagW-1:0];
    end else if (n[DataWidth-1]) begin
      m = '1;
    end else begin
      m = n[MagW-1:0];
    end
    return m;
  endfunction

  state_e               state_q;
  logic [MagW-1:0]      a_q, b_q, m_q, inv_q;
  logic [DataWidth-1:0] x0_q, x1_q, y0_q, y1_q;
  logic                 na_q, nb_q, bpos_q, inv_ok_q;

  logic                 out_valid_q;
  logic [MagW-1:0]      out_gcd_q, out_inv_q;
  logic [DataWidth-1:0] out_x_q, out_y_q;
  logic                 out_inv_ok_q;

  logic                 div_start;
  logic [MagW-1:0]      div_num, div_den, div_rem;
  logic [DataWidth-1:0] div_px, div_py;
  logic                 div_done;
  logic [MagW-1:0]      a_mag, b_mag;
  logic                 inv_start;

  assign a_mag     = mag_sat(in_i.operand_a);
  assign b_mag     = mag_sat(in_i.operand_b);
  assign inv_start = (a_q == MagW'(1)) && bpos_q;

  always_comb begin
    div_start = 1'b0;
    div_num   = a_q;
    div_den   = b_q;
    if (state_q == ST_CHECK) begin
      div_start = b_q != '0;
    end else if (state_q == ST_SIGN) begin
      div_start = inv_start;
      div_num   = mag_sat(x0_q);
      div_den   = m_q;
    end
  end

  egcd_div #(
    .DataWidth(DataWidth)
  ) u_egcd_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .mul_x_i (x1_q),
    .mul_y_i (y1_q),
    .done_o  (div_done),
    .rem_o   (div_rem),
    .prod_x_o(div_px),
    .prod_y_o(div_py)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            a_q     <= a_mag;
            b_q     <= b_mag;
            m_q     <= b_mag;
            na_q    <= in_i.operand_a[DataWidth-1];
            nb_q    <= in_i.operand_b[DataWidth-1];
            bpos_q  <= !in_i.operand_b[DataWidth-1] && (b_mag != '0);
            x0_q    <= DataWidth'(1);
            x1_q    <= '0;
            y0_q    <= '0;
            y1_q    <= DataWidth'(1);
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_q <= (b_q == '0) ? ST_SIGN : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            a_q     <= b_q;
            b_q     <= div_rem;
            x0_q    <= x1_q;
            x1_q    <= x0_q - div_px;
            y0_q    <= y1_q;
            y1_q    <= y0_q - div_py;
            state_q <= ST_CHECK;
          end
        end
        ST_SIGN: begin
          x0_q <= na_q ? -x0_q : x0_q;
          y0_q <= nb_q ? -y0_q : y0_q;
          if (inv_start) begin
            state_q <= ST_INV;
          end else begin
            inv_q    <= '0;
            inv_ok_q <= 1'b0;
            state_q  <= ST_DONE;
          end
        end
        ST_INV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              inv_q <= m_q;
            end else if (x0_q[DataWidth-1]) begin
              inv_q <= m_q - div_rem;
            end else begin
              inv_q <= div_rem;
            end
            inv_ok_q <= 1'b1;
            state_q  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_gcd_q    <= a_q;
            out_x_q      <= x0_q;
            out_y_q      <= y0_q;
            out_inv_q    <= inv_q;
            out_inv_ok_q <= inv_ok_q;
            out_valid_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready          = state_q == ST_IDLE;
  assign out_o.valid         = out_valid_q;
  assign out_o.gcd_value     = out_gcd_q;
  assign out_o.coeff_x       = out_x_q;
  assign out_o.coeff_y       = out_y_q;
  assign out_o.inverse_value = out_inv_q;
  assign out_o.inverse_valid = out_inv_ok_q;

endmodule

// ----- sv/egcd_div.sv -----
// iterative restoring divider, one quotient bit per cycle, msb first
// also accumulates quotient times two multiplicands alongside; depends on egcd_pkg
module egcd_div #(
  parameter int unsigned DataWidth = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DataWidth-2:0] num_i,
  input  logic [DataWidth-2:0] den_i,
  input  logic [DataWidth-1:0] mul_x_i,
  input  logic [DataWidth-1:0] mul_y_i,
  output logic                 done_o,
  output logic [DataWidth-2:0] rem_o,
  output logic [DataWidth-1:0] prod_x_o,
  output logic [DataWidth-1:0] prod_y_o
);
  import egcd_pkg::*;

  localparam int unsigned MagW = DataWidth - 1;
  localparam int unsigned CntW = $clog2(MagW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [MagW-1:0] num_q, den_q, rem_q, rem_d;
  logic [DataWidth-1:0] mx_q, my_q, px_q, py_q, px_d, py_d;
  logic [MagW:0]   trial;
  logic [MagW:0]   diff;
  logic            fits;

  always_comb begin
    trial = {rem_q, num_q[MagW-1]};
    fits  = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
    rem_d = fits ? diff[MagW-1:0] : trial[MagW-1:0];
    px_d  = {px_q[DataWidth-2:0], 1'b0} + (fits ? mx_q : '0);
    py_d  = {py_q[DataWidth-2:0], 1'b0} + (fits ? my_q : '0);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(MagW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      mx_q  <= mul_x_i;
      my_q  <= mul_y_i;
      rem_q <= '0;
      px_q  <= '0;
      py_q  <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[MagW-2:0], 1'b0};
      rem_q <= rem_d;
      px_q  <= px_d;
      py_q  <= py_d;
    end
  end

  assign done_o   = done_q;
  assign rem_o    = rem_q;
  assign prod_x_o = px_q;
  assign prod_y_o = py_q;

endmodule

// ----- sv/egcd_checker.sv -----
// port-level assertions for the extended gcd core, bound to the top level
// depends on egcd_pkg and extended_gcd_mod_inverse_core
module egcd_checker #(
  parameter int unsigned DataWidth = egcd_pkg::DATA_WIDTH_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [DataWidth-2:0] gcd_value_i,
  input logic [DataWidth-1:0] coeff_x_i,
  input logic [DataWidth-1:0] coeff_y_i,
  input logic [DataWidth-2:0] inverse_value_i,
  input logic                 inverse_valid_i
);
  import egcd_pkg::*;

  // the core works on one beat at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a beat is in progress");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(gcd_value_i)
      && $stable(coeff_x_i) && $stable(coeff_y_i) && $stable(inverse_value_i))
    else $error("stalled result beat changed");

  // a valid inverse needs a gcd of one and a nonzero value; it lies in 1..b
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && inverse_valid_i |-> gcd_value_i == (DataWidth-1)'(1)
      && inverse_value_i != '0)
    else $error("inverse flagged valid with gcd not one");

  // no inverse reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !inverse_valid_i |-> inverse_value_i == '0)
    else $error("inverse value not zero while not valid");

  // both operands zero gives x one, y zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && gcd_value_i == '0 |-> coeff_x_i == DataWidth'(1) && coeff_y_i == '0)
    else $error("zero gcd with unexpected coefficients");

endmodule

bind extended_gcd_mod_inverse_core egcd_checker #(
  .DataWidth(DataWidth)
) u_egcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .gcd_value_i    (out_o.gcd_value),
  .coeff_x_i      (out_o.coeff_x),
  .coeff_y_i      (out_o.coeff_y),
  .inverse_value_i(out_o.inverse_value),
  .inverse_valid_i(out_o.inverse_valid)
);
